[src/satl_pkg.sv]
`timescale 1ns / 1ps
// Package for the set-associative tag lookup unit.
// Holds the controller state type, command and status structs and fixed codes.
// No dependencies.
package satl_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } satl_state_t;

  typedef struct packed {
    logic clr_wr;
    logic req_load;
    logic upd;
  } satl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_hold;
  } satl_status_t;

  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAYS_USED   = 2'd2;

  localparam logic [1:0] FUNC_WRITE = 2'd1;

  localparam logic [4:0] OFFSET_RESET = 5'd5;
  localparam logic [3:0] INDEX_RESET  = 4'd6;
  localparam logic [3:0] WAYS_RESET   = 4'd8;

  localparam logic [4:0] OFFSET_MAX = 5'd16;
  localparam logic [3:0] INDEX_MAX  = 4'd8;

  localparam int RAW_SET_W = 8;

endpackage

[src/satl_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the tag lookup unit.
// Depends on satl_pkg for the state type and the command and status structs.
module satl_ctrl
  import satl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  satl_status_t status,
  output satl_cmd_t    cmd
);

  satl_state_t state_r;
  satl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!status.out_hold) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.clr_wr   = 1'b0;
    cmd.req_load = 1'b0;
    cmd.upd      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.req_load = in_valid;
      end
      ST_LOOKUP: begin
        cmd.upd = !status.out_hold;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[src/satl_dp.sv]
`timescale 1ns / 1ps
// Datapath of the tag lookup unit: address split, set memory, lookup and output register.
// Depends on satl_pkg for the command and status structs and fixed codes.
module satl_dp
  import satl_pkg::*;
#(
  parameter int MAX_SETS = 256,
  parameter int WAYS     = 8,
  parameter int AGE_BITS = 8,
  parameter int NW_W     = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  satl_cmd_t    cmd,
  output satl_status_t status,
  input  logic [1:0]   in_func,
  input  logic [31:0]  in_address,
  input  logic [4:0]   ob,
  input  logic [3:0]   ib,
  input  logic [NW_W-1:0] nw,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_hit,
  output logic [2:0]   out_way,
  output logic         out_filled,
  output logic         out_evicted
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WIDX  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RAW_N = 1 << RAW_SET_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  function automatic logic [RAW_N*SET_W-1:0] mk_set_tab();
    logic [RAW_N*SET_W-1:0] t;
    t = '0;
    for (int i = 0; i < RAW_N; i++) begin
      t[i*SET_W +: SET_W] = SET_W'(i % MAX_SETS);
    end
    return t;
  endfunction

  localparam logic [RAW_N*SET_W-1:0] SET_TAB = mk_set_tab();

  logic [WAYS-1:0]                mem_valid [MAX_SETS];
  logic [WAYS-1:0][31:0]          mem_tag   [MAX_SETS];
  logic [WAYS-1:0][AGE_BITS-1:0]  mem_age   [MAX_SETS];

  logic [SET_W-1:0] clr_cnt_r;
  logic [1:0]       func_r;
  logic [31:0]      tag_r;
  logic [SET_W-1:0] set_r;

  logic [WAYS-1:0]               rd_valid_r;
  logic [WAYS-1:0][31:0]         rd_tag_r;
  logic [WAYS-1:0][AGE_BITS-1:0] rd_age_r;

  logic             out_valid_r;
  logic             out_hit_r;
  logic [2:0]       out_way_r;
  logic             out_filled_r;
  logic             out_evicted_r;

  logic [31:0]          shifted;
  logic [RAW_SET_W-1:0] idx_mask;
  logic [RAW_SET_W-1:0] raw_set;
  logic [SET_W-1:0]     in_set;
  logic [5:0]           tag_shift;
  logic [31:0]          in_tag;

  assign shifted   = in_address >> ob;
  assign idx_mask  = RAW_SET_W'((9'd1 << ib) - 9'd1);
  assign raw_set   = shifted[RAW_SET_W-1:0] & idx_mask;
  assign in_set    = SET_TAB[raw_set*SET_W +: SET_W];
  assign tag_shift = {1'b0, ob} + {2'b00, ib};
  assign in_tag    = in_address >> tag_shift;

  logic [WAYS-1:0]               in_use;
  logic                          hit;
  logic [WIDX-1:0]               hit_way;
  logic                          has_free;
  logic [WIDX-1:0]               free_way;
  logic [WIDX-1:0]               old_way;
  logic [AGE_BITS-1:0]           old_age;
  logic                          is_fill;
  logic [WIDX-1:0]               victim;
  logic [WIDX-1:0]               res_way;
  logic [WAYS-1:0]               new_valid;
  logic [WAYS-1:0][31:0]         new_tag;
  logic [WAYS-1:0][AGE_BITS-1:0] new_age;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      in_use[w] = NW_W'(w) < nw;
      if (in_use[w] && rd_valid_r[w] && (rd_tag_r[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WIDX'(w);
      end
      if (in_use[w] && !rd_valid_r[w]) begin
        has_free = 1'b1;
        free_way = WIDX'(w);
      end
    end
  end

  always_comb begin
    old_way = '0;
    old_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w] && (rd_age_r[w] > old_age)) begin
        old_age = rd_age_r[w];
        old_way = WIDX'(w);
      end
    end
  end

  assign is_fill = !hit && (func_r == FUNC_WRITE);
  assign victim  = has_free ? free_way : old_way;
  assign res_way = hit ? hit_way : (is_fill ? victim : '0);

  always_comb begin
    new_valid = rd_valid_r;
    new_tag   = rd_tag_r;
    new_age   = rd_age_r;
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w]) begin
        if (hit && (hit_way == WIDX'(w))) begin
          new_age[w] = '0;
        end else if (rd_age_r[w] != AGE_MAX) begin
          new_age[w] = rd_age_r[w] + 1'b1;
        end
        if (is_fill && (victim == WIDX'(w))) begin
          new_age[w]   = '0;
          new_valid[w] = 1'b1;
          new_tag[w]   = tag_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign status.clr_last = (clr_cnt_r == SET_W'(MAX_SETS - 1));
  assign status.out_hold = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem_valid[clr_cnt_r] <= '0;
      mem_tag[clr_cnt_r]   <= '0;
      mem_age[clr_cnt_r]   <= '0;
    end else if (cmd.upd) begin
      mem_valid[set_r] <= new_valid;
      mem_tag[set_r]   <= new_tag;
      mem_age[set_r]   <= new_age;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      func_r     <= in_func;
      tag_r      <= in_tag;
      set_r      <= in_set;
      rd_valid_r <= mem_valid[in_set];
      rd_tag_r   <= mem_tag[in_set];
      rd_age_r   <= mem_age[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_hit_r     <= hit;
      out_way_r     <= 3'(res_way);
      out_filled_r  <= is_fill;
      out_evicted_r <= is_fill && !has_free;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_way     = out_way_r;
  assign out_filled  = out_filled_r;
  assign out_evicted = out_evicted_r;

endmodule

[src/set_assoc_cache_tag_lookup_unit.sv]
`timescale 1ns / 1ps
// Top level of the set-associative tag lookup unit with age-counter LRU.
// Holds the configuration registers; instantiates satl_ctrl and satl_dp; uses satl_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_func, in_address
//   out      output     out_valid / out_ready out_hit, out_way, out_filled, out_evicted
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each item has a registered read of the whole set row, then the lookup and the write-back
// of tags and ages over the single memory port; a new item is taken only after the lookup.
// After reset a clearing pass over all MAX_SETS sets zeroes the set memory; no item is
// accepted during it, while configuration writes are taken at all times.
// A result waits in the output register while the next item is accepted; the lookup
// of that item stalls until the waiting result is taken.
module set_assoc_cache_tag_lookup_unit
  import satl_pkg::*;
#(
  parameter int MAX_SETS = 256,
  parameter int WAYS     = 8,
  parameter int AGE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [2:0]  out_way,
  output logic        out_filled,
  output logic        out_evicted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int NW_W = $clog2(WAYS + 1);

  logic [4:0] offset_bits_r;
  logic [3:0] index_bits_r;
  logic [3:0] ways_used_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_RESET;
      index_bits_r  <= INDEX_RESET;
      ways_used_r   <= WAYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data;
        CFG_INDEX_BITS:  index_bits_r  <= cfg_data[3:0];
        CFG_WAYS_USED:   ways_used_r   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  logic [4:0]      ob;
  logic [3:0]      ib;
  logic [NW_W-1:0] nw;

  assign ob = (offset_bits_r > OFFSET_MAX) ? OFFSET_MAX : offset_bits_r;
  assign ib = (index_bits_r > INDEX_MAX) ? INDEX_MAX : index_bits_r;

  always_comb begin
    if (ways_used_r == 4'd0) begin
      nw = NW_W'(1);
    end else if (32'(ways_used_r) > WAYS) begin
      nw = NW_W'(WAYS);
    end else begin
      nw = NW_W'(ways_used_r);
    end
  end

  satl_cmd_t    cmd;
  satl_status_t status;

  satl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  satl_dp #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS),
    .AGE_BITS (AGE_BITS),
    .NW_W     (NW_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_func     (in_func),
    .in_address  (in_address),
    .ob          (ob),
    .ib          (ib),
    .nw          (nw),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hit     (out_hit),
    .out_way     (out_way),
    .out_filled  (out_filled),
    .out_evicted (out_evicted)
  );

`ifndef SYNTHESIS
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in the cycle after an accept");

  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a lookup cycle");

  a_evict_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_filled && !out_hit)
    else $error("eviction reported without a fill");
`endif

endmodule
